[hw/rtl/message_slot_tag_allocator_unit_assert.svh]
// Assertion macros for the slot tag allocator.
// Used by message_slot_tag_allocator_unit; expects clk and rst in scope.
`ifndef MESSAGE_SLOT_TAG_ALLOCATOR_UNIT_ASSERT_SVH
`define MESSAGE_SLOT_TAG_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define MSTA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slot allocator check failed");

// next-cycle implication
`define MSTA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slot allocator check failed");

`endif

[hw/rtl/msta_pkg.sv]
// Shared types and codes for the slot tag allocator.
// No dependencies.
package msta_pkg;

  localparam int OP_W   = 2;
  localparam int POOL_W = 2;
  localparam int TAG_W  = 7;
  localparam int ST_W   = 2;
  localparam int OFF_W  = 22;
  localparam int SIZE_W = 16;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 1;

  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_BUSY    = 2'd1;
  localparam logic [ST_W-1:0] ST_INVALID = 2'd2;

  localparam logic [IDX_W-1:0] REG_SLOTS_IN_USE = 1'b0;
  localparam logic [IDX_W-1:0] REG_SLOT_SIZE    = 1'b1;

  localparam logic [TAG_W-1:0]  SLOTS_RESET = 7'd64;
  localparam logic [SIZE_W-1:0] SIZE_RESET  = 16'd64;

  // controller -> datapath
  typedef struct packed {
    logic req_load;  // capture request, start bitmap read
    logic commit;    // write back bitmap, load result register
  } msta_cmd_t;

endpackage

[hw/rtl/msta_ctrl.sv]
// Request sequencer for the slot tag allocator.
// Depends on msta_pkg.
module msta_ctrl import msta_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output msta_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state, state_next;
  logic rsp_valid_next;
  logic can_commit;

  assign req_ready  = (state == S_IDLE);
  assign can_commit = !rsp_valid || rsp_ready;

  always_comb begin
    state_next   = state;
    cmd.req_load = 1'b0;
    cmd.commit   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.req_load = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold here while the result register is still occupied
        if (can_commit) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

[hw/rtl/msta_dpath.sv]
// Datapath: config registers, pool bitmap memory, first-free search,
// offset multiply and result register. Depends on msta_pkg.
module msta_dpath import msta_pkg::*; #(
  parameter int POOL_COUNT = 4,
  parameter int MAX_SLOTS  = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  msta_cmd_t         cmd,
  input  logic [OP_W-1:0]   op,
  input  logic [POOL_W-1:0] pool_sel,
  input  logic [TAG_W-1:0]  tag,
  output logic [ST_W-1:0]   status,
  output logic [TAG_W-1:0]  tag_out,
  output logic [OFF_W-1:0]  offset
);

  localparam int PW = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
  // only the first 127 slots are reachable through a 7-bit tag
  localparam int SW = (MAX_SLOTS < 127) ? MAX_SLOTS : 127;
  localparam logic [TAG_W-1:0] SAT = TAG_W'(SW);

  logic [TAG_W-1:0]  slots_in_use;
  logic [SIZE_W-1:0] slot_size;

  logic [MAX_SLOTS-1:0] mem [POOL_COUNT];
  logic [POOL_COUNT-1:0] row_valid;

  logic [OP_W-1:0]      op_q;
  logic [PW-1:0]        pool_q;
  logic                 pool_ok_q;
  logic [TAG_W-1:0]     tag_q;
  logic [MAX_SLOTS-1:0] rd_word;

  logic [PW+POOL_W-1:0] pool_ext;
  logic [PW-1:0]        pool_idx;
  logic                 pool_ok;

  logic [TAG_W-1:0]     n_act;
  logic                 found;
  logic [TAG_W-1:0]     free_idx;
  logic                 tag_ok;
  logic [TAG_W-1:0]     sel_idx;
  logic [MAX_SLOTS-1:0] bit_mask;
  logic [MAX_SLOTS-1:0] wr_word;
  logic                 wr_en;
  logic [ST_W-1:0]      st_next;
  logic                 hit;
  logic [SIZE_W+TAG_W-1:0] prod;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= SLOTS_RESET;
      slot_size    <= SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLOTS_IN_USE: slots_in_use <= cfg_data[TAG_W-1:0];
        REG_SLOT_SIZE:    slot_size    <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign pool_ext = {{PW{1'b0}}, pool_sel};
  assign pool_idx = pool_ext[PW-1:0];
  assign pool_ok  = (int'(pool_sel) < POOL_COUNT);

  // request capture and registered bitmap read
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      op_q      <= op;
      pool_q    <= pool_idx;
      pool_ok_q <= pool_ok;
      tag_q     <= tag;
      if (pool_ok && row_valid[pool_idx]) begin
        rd_word <= mem[pool_idx];
      end else begin
        rd_word <= '0;
      end
    end
  end

  assign n_act = (slots_in_use > SAT) ? SAT : slots_in_use;

  // lowest free slot below the active count
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = SW - 1; i >= 0; i--) begin
      if (!rd_word[i] && (TAG_W'(i) < n_act)) begin
        found    = 1'b1;
        free_idx = TAG_W'(i);
      end
    end
  end

  assign tag_ok  = (tag_q != '0) && (tag_q <= n_act);
  assign sel_idx = (op_q == OP_ALLOC) ? free_idx : (tag_q - TAG_W'(1));

  always_comb begin
    bit_mask = '0;
    for (int j = 0; j < SW; j++) begin
      bit_mask[j] = (TAG_W'(j) == sel_idx);
    end
  end

  always_comb begin
    wr_word = rd_word;
    st_next = ST_INVALID;
    wr_en   = 1'b0;
    if (pool_ok_q) begin
      case (op_q)
        OP_ALLOC: begin
          wr_word = rd_word | bit_mask;
          wr_en   = found;
          st_next = found ? ST_OK : ST_BUSY;
        end
        OP_FREE: begin
          wr_word = rd_word & ~bit_mask;
          wr_en   = tag_ok;
          st_next = tag_ok ? ST_OK : ST_INVALID;
        end
        OP_LOOKUP: begin
          st_next = tag_ok ? ST_OK : ST_INVALID;
        end
        default: st_next = ST_INVALID;
      endcase
    end
  end

  assign hit  = (st_next == ST_OK);
  assign prod = (SIZE_W+TAG_W)'(slot_size) * (SIZE_W+TAG_W)'(sel_idx);

  // bitmap write-back; rows read as all free until first written
  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      mem[pool_q] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.commit && wr_en) begin
      row_valid[pool_q] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status  <= st_next;
      tag_out <= hit ? (sel_idx + TAG_W'(1)) : '0;
      offset  <= hit ? prod[OFF_W-1:0] : '0;
    end
  end

endmodule

[hw/rtl/message_slot_tag_allocator_unit.sv]
// Slot tag allocator: first-free bitmap allocation over several message pools.
// A taken request reads its bitmap row; execute then loads the response register.
// One request at a time: bitmap read, then search + write-back, then the next.
// The result register frees the request side while a response beat waits.
// Reset (rst, synchronous): all pools free, slots_in_use = 64, slot_size = 64.
module message_slot_tag_allocator_unit import msta_pkg::*; #(
  parameter int POOL_COUNT = 4,
  parameter int MAX_SLOTS  = 64
) (
  input  logic              clk,
  input  logic              rst,
  // configuration writes
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  // request channel
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [OP_W-1:0]   op,
  input  logic [POOL_W-1:0] pool_sel,
  input  logic [TAG_W-1:0]  tag,
  // response channel
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output logic [ST_W-1:0]   status,
  output logic [TAG_W-1:0]  tag_out,
  output logic [OFF_W-1:0]  offset
);

  // Flow per request beat:
  //   accept  -> capture fields, read the pool's bitmap row (registered)
  //   execute -> find lowest free slot below the active count, or check tag,
  //              multiply slot index by slot_size, write the row back and
  //              load the response register in the same edge.
  // Execute stalls while a previous response beat is still unread.
  // Pool rows carry a valid bit cleared at reset, so an unwritten row
  // reads as all slots free.

  msta_cmd_t cmd;

  msta_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd)
  );

  msta_dpath #(
    .POOL_COUNT (POOL_COUNT),
    .MAX_SLOTS  (MAX_SLOTS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .op        (op),
    .pool_sel  (pool_sel),
    .tag       (tag),
    .status    (status),
    .tag_out   (tag_out),
    .offset    (offset)
  );

`include "message_slot_tag_allocator_unit_assert.svh"

  // a taken request keeps the request side closed in execute
  `MSTA_ASSERT_NXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
  // failed requests carry no tag and no offset
  `MSTA_ASSERT_IMP(a_fail_zero, rsp_valid && (status != ST_OK), (tag_out == '0) && (offset == '0))
  // successful requests always name a real slot
  `MSTA_ASSERT_IMP(a_ok_tag, rsp_valid && (status == ST_OK), tag_out != '0)
  // a new response only comes out of the execute cycle
  `MSTA_ASSERT_IMP(a_rsp_from_exec, $rose(rsp_valid), $past(!req_ready))

endmodule
